/* rtl/tscq_pkg.sv */
// shared types and constants of the timed speed command queue
package tscq_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TIME_BITS_DEF   = 32;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int TICK_W  = 32;
    localparam int SPEED_W = 16;
    localparam int IDENT_W = 16;
    localparam int KIND_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // event codes
    localparam logic [KIND_W-1:0] EVT_START  = 2'd0;
    localparam logic [KIND_W-1:0] EVT_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] EVT_REJECT = 2'd2;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [IDENT_W-1:0]        ident_t;

    // speed and id held by one queue slot
    typedef struct packed {
        speed_t speed;
        ident_t ident;
    } entry_data_t;

    // per-cycle control seen by every cell
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

/* rtl/tscq_if.sv */
// request and event channel interfaces
interface tscq_req_if;
    logic                              valid;
    logic                              ready;
    logic [tscq_pkg::CMD_W-1:0]        cmd;
    logic [tscq_pkg::TICK_W-1:0]       start_tick;
    logic [tscq_pkg::TICK_W-1:0]       run_ticks;
    tscq_pkg::speed_t                  task_speed;
    tscq_pkg::ident_t                  task_ident;

    modport source (output valid, cmd, start_tick, run_ticks, task_speed, task_ident,
                    input ready);
    modport sink   (input valid, cmd, start_tick, run_ticks, task_speed, task_ident,
                    output ready);
endinterface

interface tscq_evt_if;
    logic                              valid;
    logic                              ready;
    logic [tscq_pkg::KIND_W-1:0]       event_kind;
    tscq_pkg::speed_t                  drive_speed;
    tscq_pkg::ident_t                  event_ident;

    modport source (output valid, event_kind, drive_speed, event_ident, input ready);
    modport sink   (input valid, event_kind, drive_speed, event_ident, output ready);
endinterface

/* rtl/tscq_cell.sv */
// one queue slot: loads on add, takes its upper neighbor on pop
module tscq_cell #(
    parameter int TIME_BITS = tscq_pkg::TIME_BITS_DEF,
    parameter int CNT_W     = 6,
    parameter int INDEX     = 0
) (
    input  logic                   clk,
    input  tscq_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]       count,
    input  logic [TIME_BITS-1:0]   start_time,
    input  logic [TIME_BITS-1:0]   end_time,
    input  tscq_pkg::entry_data_t  start_data,
    input  tscq_pkg::entry_data_t  end_data,
    input  logic [TIME_BITS-1:0]   upper_time,
    input  tscq_pkg::entry_data_t  upper_data,
    output logic [TIME_BITS-1:0]   slot_time,
    output tscq_pkg::entry_data_t  slot_data
);

    localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_M1 = CNT_W'(INDEX - 1);

    logic [TIME_BITS-1:0]  time_reg;
    logic [TIME_BITS-1:0]  time_next;
    tscq_pkg::entry_data_t data_reg;
    tscq_pkg::entry_data_t data_next;
    logic                  hit_first;
    logic                  hit_second;

    // slot selection for the two appended entries
    assign hit_first  = (count == IDX);
    assign hit_second = (INDEX > 0) && (count == IDX_M1);

    always_comb
    begin
        time_next = time_reg;
        data_next = data_reg;
        priority if (ctrl.shift)
        begin
            time_next = upper_time;
            data_next = upper_data;
        end
        else if (ctrl.load && hit_first)
        begin
            time_next = start_time;
            data_next = start_data;
        end
        else if (ctrl.load && hit_second)
        begin
            time_next = end_time;
            data_next = end_data;
        end
        else
        begin
            time_next = time_reg;
            data_next = data_reg;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        data_reg <= data_next;
    end

    assign slot_time = time_reg;
    assign slot_data = data_reg;

endmodule

/* rtl/timed_speed_command_queue.sv */
// timed speed command queue: tick clock, shift-line entry queue, event output
// events are registered: one is offered in the cycle after the request that causes it is accepted
// throughput: one request per cycle while the event register is free or being taken
// pops shift every slot one place toward the head in the same cycle
// rst_n (async, active low) clears clock, entry count, motor speed and event valid
// slot contents are not reset; only slots below the entry count are read
module timed_speed_command_queue #(
    parameter int QUEUE_DEPTH = tscq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = tscq_pkg::TIME_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tscq_req_if.sink   req,
    tscq_evt_if.source evt
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_BITS-1:0]          now_reg;
    logic [TIME_BITS-1:0]          now_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    tscq_pkg::speed_t              speed_reg;
    tscq_pkg::speed_t              speed_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [tscq_pkg::KIND_W-1:0]   kind_reg;
    logic [tscq_pkg::KIND_W-1:0]   kind_next;
    tscq_pkg::speed_t              drive_reg;
    tscq_pkg::speed_t              drive_next;
    tscq_pkg::ident_t              ident_reg;
    tscq_pkg::ident_t              ident_next;

    logic                          accept;
    logic                          is_tick;
    logic                          is_add;
    logic                          is_clear;
    logic [TIME_BITS-1:0]          now_inc;
    logic [CNT_W:0]                count_plus2;
    logic                          full;
    logic                          fire;
    logic                          reject;
    tscq_pkg::cell_ctrl_t          ctrl;
    logic [tscq_pkg::TICK_W:0]     sum_raw;
    logic [TIME_BITS+tscq_pkg::TICK_W:0] sum_ext;
    logic [TIME_BITS+tscq_pkg::TICK_W-1:0] start_ext;
    logic [TIME_BITS-1:0]          start_time;
    logic [TIME_BITS-1:0]          end_time;
    tscq_pkg::entry_data_t         start_data;
    tscq_pkg::entry_data_t         end_data;

    logic [TIME_BITS-1:0]          slot_time [QUEUE_DEPTH];
    tscq_pkg::entry_data_t         slot_data [QUEUE_DEPTH];

    // request decode
    assign req.ready = !out_valid_reg || evt.ready;
    assign accept    = req.valid && req.ready;
    assign is_tick   = accept && (req.cmd == tscq_pkg::CMD_TICK);
    assign is_add    = accept && (req.cmd == tscq_pkg::CMD_ADD);
    assign is_clear  = accept && (req.cmd == tscq_pkg::CMD_CLEAR);

    // clock advance and head test
    assign now_inc = now_reg + TIME_BITS'(1);
    assign fire    = is_tick && (count_reg != '0) && (now_inc >= slot_time[0]);

    // room check for two entries
    assign count_plus2 = {1'b0, count_reg} + (CNT_W + 1)'(2);
    assign full        = count_plus2 > (CNT_W + 1)'(QUEUE_DEPTH);
    assign reject      = is_add && full;

    // entry times wrapped to the clock width
    assign sum_raw    = {1'b0, req.start_tick} + {1'b0, req.run_ticks};
    assign sum_ext    = {{TIME_BITS{1'b0}}, sum_raw};
    assign start_ext  = {{TIME_BITS{1'b0}}, req.start_tick};
    assign end_time   = sum_ext[TIME_BITS-1:0];
    assign start_time = start_ext[TIME_BITS-1:0];
    assign start_data = '{speed: req.task_speed, ident: req.task_ident};
    assign end_data   = '{speed: '0, ident: req.task_ident};

    assign ctrl.shift = fire;
    assign ctrl.load  = is_add && !full;

    // slot chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [TIME_BITS-1:0]  up_time;
        tscq_pkg::entry_data_t up_data;
        if (i == QUEUE_DEPTH - 1)
        begin : g_top
            assign up_time = '0;
            assign up_data = '0;
        end
        else
        begin : g_mid
            assign up_time = slot_time[i+1];
            assign up_data = slot_data[i+1];
        end
        tscq_cell #(
            .TIME_BITS (TIME_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .start_time (start_time),
            .end_time   (end_time),
            .start_data (start_data),
            .end_data   (end_data),
            .upper_time (up_time),
            .upper_data (up_data),
            .slot_time  (slot_time[i]),
            .slot_data  (slot_data[i])
        );
    end

    // control state update
    always_comb
    begin
        now_next   = now_reg;
        count_next = count_reg;
        speed_next = speed_reg;
        if (is_tick)
        begin
            now_next = now_inc;
        end
        priority if (is_clear)
        begin
            count_next = '0;
        end
        else if (ctrl.load)
        begin
            count_next = count_reg + CNT_W'(2);
        end
        else if (fire)
        begin
            count_next = count_reg - CNT_W'(1);
            speed_next = slot_data[0].speed;
        end
        else
        begin
            count_next = count_reg;
            speed_next = speed_reg;
        end
    end

    // event register
    always_comb
    begin
        out_valid_next = out_valid_reg && !evt.ready;
        kind_next      = kind_reg;
        drive_next     = drive_reg;
        ident_next     = ident_reg;
        priority if (fire)
        begin
            out_valid_next = 1'b1;
            kind_next      = (slot_data[0].speed != '0) ? tscq_pkg::EVT_START
                                                        : tscq_pkg::EVT_DONE;
            drive_next     = slot_data[0].speed;
            ident_next     = slot_data[0].ident;
        end
        else if (reject)
        begin
            out_valid_next = 1'b1;
            kind_next      = tscq_pkg::EVT_REJECT;
            drive_next     = speed_reg;
            ident_next     = req.task_ident;
        end
        else
        begin
            kind_next      = kind_reg;
            drive_next     = drive_reg;
            ident_next     = ident_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            count_reg     <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            now_reg       <= now_next;
            count_reg     <= count_next;
            speed_reg     <= speed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        drive_reg <= drive_next;
        ident_reg <= ident_next;
    end

    assign evt.valid       = out_valid_reg;
    assign evt.event_kind  = kind_reg;
    assign evt.drive_speed = drive_reg;
    assign evt.event_ident = ident_reg;

endmodule

/* rtl/tscq_checker.sv */
// port-level checks of the timed speed command queue, bound to the top level
module tscq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic [tscq_pkg::CMD_W-1:0]  req_cmd,
    input logic                        evt_valid,
    input logic                        evt_ready,
    input logic [tscq_pkg::KIND_W-1:0] evt_kind,
    input tscq_pkg::speed_t            evt_speed
);

    logic req_acc;

    assign req_acc = req_valid && req_ready;

    // a stalled event transaction keeps its contents
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_kind) && $stable(evt_speed))
        else $error("event changed while stalled");

    // a new event only follows an accepted request
    a_evt_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt_valid) |-> $past(req_acc))
        else $error("event without request");

    // start events carry a nonzero speed, done events carry zero
    a_evt_speed: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_kind != tscq_pkg::EVT_REJECT
            |-> ((evt_kind == tscq_pkg::EVT_DONE) == (evt_speed == '0)))
        else $error("event kind does not match speed");

    // a tick right after a clear finds the queue empty
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && req_cmd == tscq_pkg::CMD_CLEAR)
            ##1 (req_acc && req_cmd == tscq_pkg::CMD_TICK) |=> !evt_valid)
        else $error("event from a cleared queue");

endmodule

bind timed_speed_command_queue tscq_checker u_tscq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .evt_kind  (evt.event_kind),
    .evt_speed (evt.drive_speed)
);

/* sim/tb_timed_speed_command_queue.sv */
// testbench for the timed speed command queue: directed and random requests, checked event by event
`timescale 1ns / 1ps

module tb_timed_speed_command_queue;

    localparam int DEPTH       = tscq_pkg::QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 10;

    // code the block ignores
    localparam logic [tscq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one request transaction
    typedef struct packed {
        logic [tscq_pkg::CMD_W-1:0]  cmd;
        logic [tscq_pkg::TICK_W-1:0] start_tick;
        logic [tscq_pkg::TICK_W-1:0] run_ticks;
        tscq_pkg::speed_t            task_speed;
        tscq_pkg::ident_t            task_ident;
    } speed_req_t;

    // one event transaction
    typedef struct packed {
        logic [tscq_pkg::KIND_W-1:0] kind;
        tscq_pkg::speed_t            speed;
        tscq_pkg::ident_t            ident;
    } motor_event_t;

    logic clk;
    logic rst_n;

    tscq_req_if req_bus ();
    tscq_evt_if evt_bus ();

    timed_speed_command_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .evt   (evt_bus)
    );

    // queue mirror
    logic [tscq_pkg::TICK_W-1:0] clock_ticks;
    logic [tscq_pkg::TICK_W-1:0] slot_time [DEPTH];
    tscq_pkg::speed_t            slot_speed [DEPTH];
    tscq_pkg::ident_t            slot_ident [DEPTH];
    int                          slot_count;
    tscq_pkg::speed_t            applied_speed;

    motor_event_t expected_events [$];

    int mismatch_count;
    int requests_sent;
    int starts_seen;
    int dones_seen;
    int rejects_seen;
    int cycle_count;

    // sender burst state
    int burst_left;

    // receiver stall pattern state
    int stall_phase;
    int stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    function automatic speed_req_t make_request(input logic [tscq_pkg::CMD_W-1:0] cmd,
                                                input logic [tscq_pkg::TICK_W-1:0] start_tick,
                                                input logic [tscq_pkg::TICK_W-1:0] run_ticks,
                                                input tscq_pkg::speed_t speed,
                                                input tscq_pkg::ident_t ident);
        speed_req_t item;
        item.cmd        = cmd;
        item.start_tick = start_tick;
        item.run_ticks  = run_ticks;
        item.task_speed = speed;
        item.task_ident = ident;
        return item;
    endfunction

    // apply one accepted request to the mirror and queue any event it causes
    function automatic void predict_queue_event(input speed_req_t item);
        motor_event_t ev;
        int i;
        case (item.cmd)
            tscq_pkg::CMD_TICK:
            begin
                clock_ticks = clock_ticks + 1'b1;
                if (slot_count > 0 && clock_ticks >= slot_time[0])
                begin
                    applied_speed = slot_speed[0];
                    ev.kind       = (applied_speed != 0) ? tscq_pkg::EVT_START
                                                         : tscq_pkg::EVT_DONE;
                    ev.speed      = applied_speed;
                    ev.ident      = slot_ident[0];
                    expected_events.push_back(ev);
                    // head pops, the rest move up one place
                    for (i = 0; i < DEPTH - 1; i++)
                    begin
                        slot_time[i]  = slot_time[i + 1];
                        slot_speed[i] = slot_speed[i + 1];
                        slot_ident[i] = slot_ident[i + 1];
                    end
                    slot_count--;
                end
            end
            tscq_pkg::CMD_ADD:
            begin
                if (slot_count + 2 > DEPTH)
                begin
                    ev.kind  = tscq_pkg::EVT_REJECT;
                    ev.speed = applied_speed;
                    ev.ident = item.task_ident;
                    expected_events.push_back(ev);
                end
                else
                begin
                    // start entry, then stop entry at start plus duration
                    slot_time[slot_count]      = item.start_tick;
                    slot_speed[slot_count]     = item.task_speed;
                    slot_ident[slot_count]     = item.task_ident;
                    slot_time[slot_count + 1]  = item.start_tick + item.run_ticks;
                    slot_speed[slot_count + 1] = '0;
                    slot_ident[slot_count + 1] = item.task_ident;
                    slot_count += 2;
                end
            end
            tscq_pkg::CMD_CLEAR:
            begin
                slot_count = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // drive one request transaction, idling between bursts
    task automatic send_request(input speed_req_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                req_bus.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_bus.valid      = 1'b1;
        req_bus.cmd        = item.cmd;
        req_bus.start_tick = item.start_tick;
        req_bus.run_ticks  = item.run_ticks;
        req_bus.task_speed = item.task_speed;
        req_bus.task_ident = item.task_ident;
        do
            @(posedge clk);
        while (!req_bus.ready);
        predict_queue_event(item);
        requests_sent++;
    endtask

    // receiver ready pattern: free running, random, or long stalls
    always @(negedge clk)
    begin
        stall_phase++;
        if (stall_phase % 128 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       evt_bus.ready = 1'b1;
            1:       evt_bus.ready = ($urandom_range(0, 3) != 0);
            default: evt_bus.ready = (stall_phase % 8 == 0);
        endcase
    end

    // check each event transaction against the oldest expectation
    always @(posedge clk)
    begin
        motor_event_t want;
        if (rst_n && evt_bus.valid && evt_bus.ready)
        begin
            if (expected_events.size() == 0)
            begin
                report_mismatch("unexpected event kind", -1, evt_bus.event_kind);
            end
            else
            begin
                want = expected_events.pop_front();
                if (evt_bus.event_kind !== want.kind)
                    report_mismatch("event_kind", want.kind, evt_bus.event_kind);
                if (evt_bus.drive_speed !== want.speed)
                    report_mismatch("drive_speed", want.speed, evt_bus.drive_speed);
                if (evt_bus.event_ident !== want.ident)
                    report_mismatch("event_ident", want.ident, evt_bus.event_ident);
                case (want.kind)
                    tscq_pkg::EVT_START: starts_seen++;
                    tscq_pkg::EVT_DONE:  dones_seen++;
                    default:             rejects_seen++;
                endcase
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events still pending",
                     cycle_count, expected_events.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // speed applied on a later tick, then stop one tick after
    task automatic test_start_then_done();
        send_request(make_request(tscq_pkg::CMD_ADD, clock_ticks + 2, 32'd1,
                                  16'sh7fff, 16'hffff));
        repeat (3) send_request(make_request(tscq_pkg::CMD_TICK, '0, '0, '0, '0));
    endtask

    // entries already due fire one per tick; zero speed start reads as done
    task automatic test_due_backlog();
        send_request(make_request(tscq_pkg::CMD_ADD, 32'd0, 32'd0, 16'sh0000, 16'h0000));
        // end time wraps past the top of the clock
        send_request(make_request(tscq_pkg::CMD_ADD, clock_ticks, 32'hffff_ffff,
                                  16'sh8000, 16'h8000));
        repeat (3) send_request(make_request(tscq_pkg::CMD_TICK, '0, '0, '0, '0));
    endtask

    // fill to one free slot, add is rejected, then ignored code and clear
    task automatic test_full_queue();
        int i;
        for (i = 0; slot_count + 2 <= DEPTH; i++)
            send_request(make_request(tscq_pkg::CMD_ADD, 32'hffff_ffff - i, $urandom,
                                      tscq_pkg::speed_t'($urandom),
                                      tscq_pkg::ident_t'(i)));
        send_request(make_request(tscq_pkg::CMD_ADD, 32'h0, 32'h0, 16'sh1234, 16'h5a5a));
        send_request(make_request(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff,
                                  16'shffff, 16'hffff));
        send_request(make_request(tscq_pkg::CMD_CLEAR, $urandom, $urandom,
                                  tscq_pkg::speed_t'($urandom),
                                  tscq_pkg::ident_t'($urandom)));
    endtask

    // mostly near-term tasks and ticks, with far, wrapping and junk requests mixed in
    task automatic test_random_traffic(input int count);
        int sent;
        int pick;
        bit far_head;
        tscq_pkg::speed_t speed;
        speed_req_t item;
        sent = 0;
        while (sent < count)
        begin
            pick     = $urandom_range(0, 99);
            far_head = slot_count > 0 && slot_time[0] > clock_ticks
                       && slot_time[0] - clock_ticks > 40;
            speed    = ($urandom_range(0, 7) == 0) ? 16'sh0 : tscq_pkg::speed_t'($urandom);
            item     = make_request(tscq_pkg::CMD_TICK, $urandom, $urandom, speed,
                                    tscq_pkg::ident_t'($urandom));
            if (far_head && pick < 30)
                item.cmd = tscq_pkg::CMD_CLEAR;
            else if (pick < 55)
                item.cmd = tscq_pkg::CMD_TICK;
            else if (pick < 77)
            begin
                item.cmd        = tscq_pkg::CMD_ADD;
                item.start_tick = clock_ticks + $urandom_range(0, 10);
                item.run_ticks  = $urandom_range(0, 12);
            end
            else if (pick < 82)
            begin
                // start already in the past
                item.cmd        = tscq_pkg::CMD_ADD;
                item.start_tick = clock_ticks - $urandom_range(0, 20);
                item.run_ticks  = $urandom_range(0, 12);
            end
            else if (pick < 86)
                item.cmd = tscq_pkg::CMD_ADD;
            else if (pick < 89)
            begin
                // near start, random duration that can wrap the end time
                item.cmd        = tscq_pkg::CMD_ADD;
                item.start_tick = clock_ticks + $urandom_range(0, 4);
            end
            else if (pick < 95)
                item.cmd = tscq_pkg::CMD_CLEAR;
            else
                item.cmd = CMD_UNUSED;
            send_request(item);
            if (item.cmd != CMD_UNUSED)
                sent++;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.cmd        = tscq_pkg::CMD_TICK;
        req_bus.start_tick = '0;
        req_bus.run_ticks  = '0;
        req_bus.task_speed = '0;
        req_bus.task_ident = '0;
        evt_bus.ready      = 1'b0;
        clock_ticks        = '0;
        slot_count         = 0;
        applied_speed      = '0;
        mismatch_count     = 0;
        requests_sent      = 0;
        starts_seen        = 0;
        dones_seen         = 0;
        rejects_seen       = 0;
        cycle_count        = 0;
        burst_left         = 0;
        stall_phase        = 0;
        stall_mode         = 0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_start_then_done();
        test_due_backlog();
        test_full_queue();
        test_random_traffic(900);

        @(negedge clk);
        req_bus.valid = 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests sent; checked %0d start, %0d done and %0d reject events",
                 requests_sent, starts_seen, dones_seen, rejects_seen);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
